/* rtl/cep_pkg.sv */
`timescale 1ns / 1ps

package cep_pkg;

    localparam int MAX_DATA_SHARDS_DEF   = 32;
    localparam int MAX_PARITY_SHARDS_DEF = 32;

    localparam int K_W        = 6;
    localparam int N_W        = 7;
    localparam int ROWS_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int SHARD_W    = 5;
    localparam int PSHARD_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [8:0] FIELD_POLY = 9'h11d;
    localparam int         N_LIMIT    = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_SHARD_COUNT  = 2'd0,
        REG_TOTAL_SHARD_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic update;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef logic [BYTE_W-1:0] inv_tbl_t [256];

    // gf(2^8) product, shift-and-add over eight bits
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [8:0]        x;
        logic [BYTE_W-1:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
                acc = acc ^ x[BYTE_W-1:0];
            x = {x[BYTE_W-1:0], 1'b0};
            if (x[8])
                x = x ^ FIELD_POLY;
        end
        return acc;
    endfunction

    // inverse table, built at elaboration; zero maps to zero
    function automatic inv_tbl_t build_inv_tbl();
        inv_tbl_t tbl;
        for (int a = 0; a < 256; a++)
        begin
            tbl[a] = '0;
            for (int b = 1; b < 256; b++)
            begin
                if (gf_mul(BYTE_W'(a), BYTE_W'(b)) == 8'd1)
                    tbl[a] = BYTE_W'(b);
            end
        end
        return tbl;
    endfunction

    localparam inv_tbl_t INV_TBL = build_inv_tbl();

endpackage

/* rtl/cep_cell.sv */
`timescale 1ns / 1ps

module cep_cell #(
    parameter int ROW = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cep_pkg::cell_ctrl_t         ctrl,
    input  logic [cep_pkg::ROWS_W-1:0]  rows,
    input  logic [cep_pkg::K_W-1:0]     k,
    input  logic [cep_pkg::SHARD_W-1:0] shard,
    input  logic [cep_pkg::BYTE_W-1:0]  data,
    input  logic [cep_pkg::BYTE_W-1:0]  shift_in,
    output logic [cep_pkg::BYTE_W-1:0]  acc
);
    import cep_pkg::*;

    localparam logic [BYTE_W-1:0] ROW_IDX = BYTE_W'(ROW);

    logic [BYTE_W-1:0] acc_reg;
    logic [BYTE_W-1:0] acc_next;
    logic [BYTE_W-1:0] row_id;
    logic [BYTE_W-1:0] coef;
    logic              row_en;

    // coefficient is inv(i xor j) with i = k + row
    assign row_id = ({{(BYTE_W-K_W){1'b0}}, k} + ROW_IDX)
                    ^ {{(BYTE_W-SHARD_W){1'b0}}, shard};
    assign coef   = INV_TBL[row_id];
    assign row_en = ({1'b0, ROW_IDX} < {{(BYTE_W+1-ROWS_W){1'b0}}, rows});

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.shift)
            acc_next = shift_in;
        else if (ctrl.update && row_en)
            acc_next = acc_reg ^ gf_mul(coef, data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* rtl/cauchy_erasure_parity_encoder_unit.sv */
`timescale 1ns / 1ps

// cauchy erasure parity encoder, gf(2^8) with polynomial 0x11d. data bytes come in
// column by column, each tagged with its data shard j; parity row i = k..n-1 keeps
// the xor of data * inv(i xor j). a beat carrying column_end closes the column: the
// block then sends n-k parity beats in row order (one beat with dimension_error set
// and zero parity if k and n are not a valid pair) and clears all accumulators.
// bytes of shard k or above are not accumulated but still honor column_end.
// rate: bytes without column_end stream at one per clock; a beat is registered in an
// input register and the cell row updates from it in the cycle after. after a column
// end the block shifts the parity beats (n-k, or one on error) out of the cell chain,
// holding while the output stalls; input is stalled from the column end through that
// drain. the user must write config only between columns or while no beat is in
// flight; the block itself does not enforce this.
module cauchy_erasure_parity_encoder_unit #(
    parameter int MAX_DATA_SHARDS   = cep_pkg::MAX_DATA_SHARDS_DEF,
    parameter int MAX_PARITY_SHARDS = cep_pkg::MAX_PARITY_SHARDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_we,
    input  logic [cep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cep_pkg::CFG_DATA_W-1:0] cfg_data,
    // input beats
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cep_pkg::BYTE_W-1:0]     data_byte,
    input  logic [cep_pkg::SHARD_W-1:0]    shard_index,
    input  logic                           column_end,
    // parity beats
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cep_pkg::BYTE_W-1:0]     parity_byte,
    output logic [cep_pkg::PSHARD_W-1:0]   parity_shard,
    output logic                           dimension_error,
    output logic                           last_of_column
);
    import cep_pkg::*;

    localparam int CNT_W = (MAX_PARITY_SHARDS > 1) ? $clog2(MAX_PARITY_SHARDS) : 1;

    // configuration registers
    logic [K_W-1:0] k_reg;
    logic [N_W-1:0] n_reg;

    // input holding register, one beat deep
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [BYTE_W-1:0]  pend_byte_reg;
    logic [SHARD_W-1:0] pend_shard_reg;
    logic               pend_end_reg;

    // drain control
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             err_reg;
    logic             err_next;

    logic              dims_ok;
    logic [ROWS_W-1:0] rows;
    logic              in_accept;
    logic              out_accept;
    logic              last_row;
    cell_ctrl_t        cell_ctrl;
    logic [BYTE_W-1:0] acc [MAX_PARITY_SHARDS];

    // config decode, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_W'(1);
            n_reg <= N_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DATA_SHARD_COUNT:  k_reg <= cfg_data[K_W-1:0];
                REG_TOTAL_SHARD_COUNT: n_reg <= cfg_data[N_W-1:0];
                default: ;
            endcase
        end
    end

    // valid pair: 1 <= k <= max data, k < n <= 255, n - k <= max parity
    always_comb
    begin
        dims_ok = (k_reg != '0)
               && (int'(k_reg) <= MAX_DATA_SHARDS)
               && ({1'b0, k_reg} < n_reg)
               && (int'(n_reg) <= N_LIMIT)
               && ((int'(n_reg) - int'(k_reg)) <= MAX_PARITY_SHARDS);
        rows = dims_ok ? (n_reg - {1'b0, k_reg}) : '0;
    end

    // no new beat while a column end waits or the chain drains
    assign in_stall        = (state_reg == ST_DRAIN) || (pend_valid_reg && pend_end_reg);
    assign in_accept       = in_valid && !in_stall;
    assign pend_valid_next = in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= pend_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_byte_reg  <= data_byte;
            pend_shard_reg <= shard_index;
            pend_end_reg   <= column_end;
        end
    end

    assign out_valid  = (state_reg == ST_DRAIN);
    assign out_accept = out_valid && !out_stall;
    assign last_row   = (ROWS_W'(cnt_reg) == rows - ROWS_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        cell_ctrl.update = 1'b0;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.clear  = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                // foreign shards and bad dimensions leave the accumulators alone
                cell_ctrl.update = pend_valid_reg && dims_ok
                                && ({1'b0, pend_shard_reg} < k_reg);
                if (pend_valid_reg && pend_end_reg)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                    err_next   = !dims_ok;
                end
            end
            ST_DRAIN:
            begin
                if (out_accept)
                begin
                    if (err_reg || last_row)
                    begin
                        // column done, wipe every row including unused ones
                        cell_ctrl.clear = 1'b1;
                        state_next      = ST_RUN;
                    end
                    else
                    begin
                        cell_ctrl.shift = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // row of accumulator cells, parity shifts toward cell 0 on drain
    for (genvar r = 0; r < MAX_PARITY_SHARDS; r++)
    begin : g_cell
        logic [BYTE_W-1:0] shift_in;
        if (r == MAX_PARITY_SHARDS - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_link
            assign shift_in = acc[r+1];
        end

        cep_cell #(
            .ROW (r)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .rows     (rows),
            .k        (k_reg),
            .shard    (pend_shard_reg),
            .data     (pend_byte_reg),
            .shift_in (shift_in),
            .acc      (acc[r])
        );
    end

    assign parity_byte     = err_reg ? '0 : acc[0];
    assign parity_shard    = err_reg ? '0 : (PSHARD_W'(k_reg) + PSHARD_W'(cnt_reg));
    assign dimension_error = err_reg;
    assign last_of_column  = err_reg || last_row;

endmodule
